### hw/rtl/mfs_pkg.sv
// Shared types, constants and lookup tables of the MP3 frame scanner.
package mfs_pkg;

  localparam int unsigned MaxFrameBytesDef = 2048;

  // Shared divider geometry: a 43-bit dividend and quotient, a 32-bit divisor.
  localparam int unsigned DivQW   = 43;
  localparam int unsigned DivRW   = 32;
  localparam int unsigned DivCntW = $clog2(DivQW + 1);

  localparam logic [DivCntW-1:0] SizeSteps = DivCntW'(12);
  localparam logic [DivCntW-1:0] DurSteps  = DivCntW'(DivQW);
  localparam logic [DivCntW-1:0] AvgSteps  = DivCntW'(9);

  localparam logic [1:0] ClsPending = 2'd0;
  localparam logic [1:0] ClsGarbage = 2'd1;
  localparam logic [1:0] ClsStart   = 2'd2;
  localparam logic [1:0] ClsBody    = 2'd3;

  localparam logic [1:0] VerNone  = 2'd0;
  localparam logic [1:0] VerMpeg1 = 2'd1;
  localparam logic [1:0] VerMpeg2 = 2'd2;

  localparam logic [7:0]  SyncByte    = 8'hFF;
  localparam logic [3:0]  SyncNibFull = 4'hF;
  localparam logic [3:0]  SyncNibExt  = 4'hE;
  localparam logic [25:0] SizeScaleV1 = 26'd144000;
  localparam logic [25:0] SizeScaleV2 = 26'd72000;
  localparam logic [10:0] SpfV1       = 11'd1152;
  localparam logic [10:0] SpfV2       = 11'd576;
  localparam logic [8:0]  KbpsCeiling = 9'd320;
  localparam logic [1:0]  ModeMono    = 2'b11;

  // Multiply-and-shift that equals a division by 1000 for any 16-bit value.
  localparam logic [16:0] KhzRecip = 17'd67109;
  localparam int unsigned KhzShift = 26;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } mfs_in_t;

  typedef struct packed {
    logic [1:0]  byte_class;
    logic [11:0] frame_bytes;
    logic [8:0]  constant_kbps;
    logic [31:0] frame_count;
    logic [31:0] garbage_count;
    logic [31:0] good_byte_count;
    logic [15:0] sample_rate_hz;
    logic [1:0]  mpeg_version;
    logic        is_stereo;
    logic [31:0] duration_ms;
    logic [8:0]  avg_kbps;
    logic        final_res;
  } mfs_out_t;

  typedef struct packed {
    logic               start;
    logic [DivCntW-1:0] count;
    logic [DivRW-1:0]   divisor;
    logic [DivRW-1:0]   rem_init;
    logic [DivQW-1:0]   quo_init;
  } mfs_div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DivQW-1:0] quotient;
  } mfs_div_rsp_t;

  function automatic logic [8:0] kbps_lookup(input logic v1, input logic [3:0] idx);
    logic [8:0] k;
    if (v1) begin
      case (idx)
        4'd1:    k = 9'd32;
        4'd2:    k = 9'd40;
        4'd3:    k = 9'd48;
        4'd4:    k = 9'd56;
        4'd5:    k = 9'd64;
        4'd6:    k = 9'd80;
        4'd7:    k = 9'd96;
        4'd8:    k = 9'd112;
        4'd9:    k = 9'd128;
        4'd10:   k = 9'd160;
        4'd11:   k = 9'd192;
        4'd12:   k = 9'd224;
        4'd13:   k = 9'd256;
        4'd14:   k = 9'd320;
        default: k = 9'd0;
      endcase
    end else begin
      case (idx)
        4'd1:    k = 9'd8;
        4'd2:    k = 9'd16;
        4'd3:    k = 9'd24;
        4'd4:    k = 9'd32;
        4'd5:    k = 9'd40;
        4'd6:    k = 9'd48;
        4'd7:    k = 9'd56;
        4'd8:    k = 9'd64;
        4'd9:    k = 9'd80;
        4'd10:   k = 9'd96;
        4'd11:   k = 9'd112;
        4'd12:   k = 9'd128;
        4'd13:   k = 9'd144;
        4'd14:   k = 9'd160;
        default: k = 9'd0;
      endcase
    end
    return k;
  endfunction

  function automatic logic [15:0] rate_lookup(input logic v1, input logic [1:0] idx);
    logic [15:0] r;
    case (idx)
      2'd0:    r = v1 ? 16'd44100 : 16'd22050;
      2'd1:    r = v1 ? 16'd48000 : 16'd24000;
      2'd2:    r = v1 ? 16'd32000 : 16'd16000;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/mfs_in_if.sv
// Input channel of the frame scanner: valid, ready and one file byte with its end-of-stream flag.
interface mfs_in_if import mfs_pkg::*; ();
  logic    valid;
  logic    ready;
  mfs_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/mfs_out_if.sv
// Output channel of the frame scanner: valid, ready and one result.
interface mfs_out_if import mfs_pkg::*; ();
  logic     valid;
  logic     ready;
  mfs_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/mfs_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle, preloaded remainder.
module mfs_divider import mfs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  mfs_div_req_t req_i,
  output mfs_div_rsp_t rsp_o
);

  logic [DivRW-1:0]   rem_q, rem_d;
  logic [DivQW-1:0]   quo_q, quo_d;
  logic [DivRW-1:0]   dvs_q, dvs_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;

  logic [DivRW:0] shifted;
  logic [DivRW:0] diff;
  logic           fits;

  assign shifted = {rem_q, quo_q[DivQW-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = req_i.rem_init;
      quo_d  = req_i.quo_init;
      dvs_d  = req_i.divisor;
      cnt_d  = req_i.count;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // The remainder stays below the divisor, so it fits DivRW bits.
      rem_d = fits ? diff[DivRW-1:0] : shifted[DivRW-1:0];
      quo_d = {quo_q[DivQW-2:0], fits};
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

### hw/rtl/mp3_frame_scanner.sv
// MP3 frame scanner: byte window, header check, frame sizing and stream totals.
// A byte while the window fills goes from IDLE to DONE; a frame body byte or a rejected
// sync also passes through CHECK, a header candidate CHECK and SIZE (12 divider steps
// for the frame size). An end-of-stream byte then runs FIN, DURGO, DUR (43 divider steps
// for the duration) and AVG (9 for the average bitrate), or only FIN if not an MP3.
// One byte is in work at a time; the shared divider and the output's ready set the pace.
// Reset (asynchronous, active low) clears the window, counters and locked values.
module mp3_frame_scanner import mfs_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = MaxFrameBytesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  mfs_in_if.sink           in_i,
  mfs_out_if.source        out_o
);

  localparam int unsigned BodyW = $clog2(MAX_FRAME_BYTES);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_SIZE   = 3'd2;
  localparam logic [2:0] ST_FIN    = 3'd3;
  localparam logic [2:0] ST_DURGO  = 3'd4;
  localparam logic [2:0] ST_DUR    = 3'd5;
  localparam logic [2:0] ST_AVG    = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Control and stream state.
  logic [2:0]       state_q, state_d;
  logic [7:0]       win_q [4];
  logic [7:0]       win_d [4];
  logic [1:0]       fill_q, fill_d;
  logic [BodyW-1:0] body_q, body_d;
  logic [31:0]      frames_q, frames_d;
  logic [31:0]      garbage_q, garbage_d;
  logic [31:0]      good_q, good_d;
  logic [15:0]      lrate_q, lrate_d;
  logic [8:0]       lkbps_q, lkbps_d;
  logic [1:0]       lver_q, lver_d;
  logic             lstereo_q, lstereo_d;
  logic [40:0]      ksum_q, ksum_d;
  logic             out_valid_q, out_valid_d;

  // Per-transaction working values.
  logic             eos_q, eos_d;
  logic [1:0]       cls_q, cls_d;
  logic [11:0]      fsize_q, fsize_d;
  logic             bad_q, bad_d;
  logic [DivQW-1:0] prod_q, prod_d;
  logic [6:0]       khz_q, khz_d;
  logic [31:0]      dur_q, dur_d;
  logic [8:0]       avg_q, avg_d;
  mfs_out_t         out_q, out_d;

  logic             in_ready;
  logic             load_out;
  logic             do_shift;
  logic             bad_now;
  logic [32:0]      khz_full;

  mfs_div_req_t     div_req;
  mfs_div_rsp_t     div_rsp;

  // Header fields of the window as it stands.
  logic        hdr_v1;
  logic [15:0] hdr_rate;
  logic [8:0]  hdr_kbps;
  logic        hdr_pad;
  logic        hdr_stereo;
  logic        sync_ok;
  logic [25:0] size_num;
  logic [11:0] size;
  logic        size_bad;
  logic [8:0]  avg_raw;

  assign hdr_v1     = win_q[1][3];
  assign hdr_rate   = rate_lookup(hdr_v1, win_q[2][3:2]);
  assign hdr_kbps   = kbps_lookup(hdr_v1, win_q[2][7:4]);
  assign hdr_pad    = win_q[2][1];
  assign hdr_stereo = win_q[3][7:6] != ModeMono;
  assign sync_ok    = (win_q[0] == SyncByte)
                   && (win_q[1][7:4] == SyncNibFull || win_q[1][7:4] == SyncNibExt)
                   && (hdr_rate != 16'd0);
  assign size_num   = (hdr_v1 ? SizeScaleV1 : SizeScaleV2) * {17'd0, hdr_kbps};
  assign size       = div_rsp.quotient[11:0] + {11'd0, hdr_pad};
  assign size_bad   = (size <= 12'd1) || (32'(size) > 32'(MAX_FRAME_BYTES));
  assign avg_raw    = div_rsp.quotient[8:0];
  assign bad_now    = (garbage_q > good_q) || (good_q == 32'd0);
  assign khz_full   = {17'd0, lrate_q} * {16'd0, KhzRecip};

  mfs_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d   = state_q;
    win_d     = win_q;
    fill_d    = fill_q;
    body_d    = body_q;
    frames_d  = frames_q;
    garbage_d = garbage_q;
    good_d    = good_q;
    lrate_d   = lrate_q;
    lkbps_d   = lkbps_q;
    lver_d    = lver_q;
    lstereo_d = lstereo_q;
    ksum_d    = ksum_q;
    eos_d     = eos_q;
    cls_d     = cls_q;
    fsize_d   = fsize_q;
    bad_d     = bad_q;
    prod_d    = prod_q;
    khz_d     = khz_q;
    dur_d     = dur_q;
    avg_d     = avg_q;
    div_req   = '0;
    in_ready  = 1'b0;
    load_out  = 1'b0;
    do_shift  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          win_d[fill_q] = in_i.payload.data_byte;
          eos_d   = in_i.payload.end_of_stream;
          cls_d   = ClsPending;
          fsize_d = 12'd0;
          bad_d   = 1'b0;
          dur_d   = 32'd0;
          avg_d   = 9'd0;
          if (fill_q == 2'd3) begin
            state_d = ST_CHECK;
          end else begin
            fill_d  = fill_q + 2'd1;
            state_d = in_i.payload.end_of_stream ? ST_FIN : ST_DONE;
          end
        end
      end
      ST_CHECK: begin
        if (body_q != '0) begin
          body_d   = body_q - BodyW'(1);
          cls_d    = ClsBody;
          do_shift = 1'b1;
          state_d  = eos_q ? ST_FIN : ST_DONE;
        end else if (!sync_ok) begin
          garbage_d = sat_add32(garbage_q, 32'd1);
          cls_d     = ClsGarbage;
          do_shift  = 1'b1;
          state_d   = eos_q ? ST_FIN : ST_DONE;
        end else begin
          // The quotient stays below 4096, so only its 12 low bits are developed.
          div_req.start    = 1'b1;
          div_req.count    = SizeSteps;
          div_req.divisor  = {16'd0, hdr_rate};
          div_req.rem_init = {18'd0, size_num[25:12]};
          div_req.quo_init = {size_num[11:0], 31'd0};
          state_d          = ST_SIZE;
        end
      end
      ST_SIZE: begin
        if (div_rsp.done) begin
          if (size_bad || (frames_q != 32'd0 && lrate_q != hdr_rate)) begin
            garbage_d = sat_add32(garbage_q, 32'd1);
            cls_d     = ClsGarbage;
          end else begin
            if (frames_q == 32'd0) begin
              lrate_d   = hdr_rate;
              lkbps_d   = hdr_kbps;
              lver_d    = hdr_v1 ? VerMpeg1 : VerMpeg2;
              lstereo_d = hdr_stereo;
            end else if (lkbps_q != 9'd0 && lkbps_q != hdr_kbps) begin
              lkbps_d = 9'd0;
            end
            if (frames_q != 32'hFFFF_FFFF) begin
              ksum_d = ksum_q + {32'd0, hdr_kbps};
            end
            frames_d = sat_add32(frames_q, 32'd1);
            good_d   = sat_add32(good_q, {20'd0, size});
            body_d   = BodyW'(size - 12'd1);
            fsize_d  = size;
            cls_d    = ClsStart;
          end
          do_shift = 1'b1;
          state_d  = eos_q ? ST_FIN : ST_DONE;
        end
      end
      ST_FIN: begin
        bad_d = bad_now;
        if (bad_now) begin
          state_d = ST_DONE;
        end else begin
          prod_d  = {11'd0, frames_q} * {32'd0, (lver_q == VerMpeg1) ? SpfV1 : SpfV2};
          khz_d   = khz_full[KhzShift +: 7];
          state_d = ST_DURGO;
        end
      end
      ST_DURGO: begin
        div_req.start    = 1'b1;
        div_req.count    = DurSteps;
        div_req.divisor  = {25'd0, khz_q};
        div_req.rem_init = '0;
        div_req.quo_init = prod_q;
        state_d          = ST_DUR;
      end
      ST_DUR: begin
        if (div_rsp.done) begin
          if (khz_q == 7'd0) begin
            dur_d = 32'd0;
          end else if (div_rsp.quotient[DivQW-1:32] != '0) begin
            dur_d = 32'hFFFF_FFFF;
          end else begin
            dur_d = div_rsp.quotient[31:0];
          end
          // The mean bitrate is below 512, so 9 quotient bits suffice.
          div_req.start    = 1'b1;
          div_req.count    = AvgSteps;
          div_req.divisor  = frames_q;
          div_req.rem_init = ksum_q[40:9];
          div_req.quo_init = {ksum_q[8:0], 34'd0};
          state_d          = ST_AVG;
        end
      end
      ST_AVG: begin
        if (div_rsp.done) begin
          if (frames_q == 32'd0) begin
            avg_d = 9'd0;
          end else begin
            avg_d = (avg_raw > KbpsCeiling) ? KbpsCeiling : avg_raw;
          end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (do_shift) begin
      win_d[0] = win_q[1];
      win_d[1] = win_q[2];
      win_d[2] = win_q[3];
      win_d[3] = 8'd0;
      fill_d   = 2'd3;
    end

    // The final result starts a new stream.
    if (load_out && eos_q) begin
      for (int i = 0; i < 4; i++) begin
        win_d[i] = 8'd0;
      end
      fill_d    = 2'd0;
      body_d    = '0;
      frames_d  = 32'd0;
      garbage_d = 32'd0;
      good_d    = 32'd0;
      lrate_d   = 16'd0;
      lkbps_d   = 9'd0;
      lver_d    = VerNone;
      lstereo_d = 1'b0;
      ksum_d    = 41'd0;
    end
  end

  always_comb begin
    out_d = out_q;
    if (load_out) begin
      out_d.byte_class      = cls_q;
      out_d.frame_bytes     = fsize_q;
      out_d.constant_kbps   = lkbps_q;
      out_d.frame_count     = frames_q;
      out_d.garbage_count   = garbage_q;
      out_d.good_byte_count = good_q;
      out_d.sample_rate_hz  = lrate_q;
      out_d.mpeg_version    = lver_q;
      out_d.is_stereo       = lstereo_q;
      out_d.duration_ms     = dur_q;
      out_d.avg_kbps        = avg_q;
      out_d.final_res       = eos_q;
      if (eos_q && bad_q) begin
        out_d.constant_kbps   = 9'd0;
        out_d.frame_count     = 32'd0;
        out_d.garbage_count   = 32'd0;
        out_d.good_byte_count = 32'd0;
        out_d.sample_rate_hz  = 16'd0;
        out_d.mpeg_version    = VerNone;
        out_d.is_stereo       = 1'b0;
        out_d.duration_ms     = 32'd0;
        out_d.avg_kbps        = 9'd0;
      end
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      for (int i = 0; i < 4; i++) begin
        win_q[i] <= 8'd0;
      end
      fill_q      <= 2'd0;
      body_q      <= '0;
      frames_q    <= 32'd0;
      garbage_q   <= 32'd0;
      good_q      <= 32'd0;
      lrate_q     <= 16'd0;
      lkbps_q     <= 9'd0;
      lver_q      <= VerNone;
      lstereo_q   <= 1'b0;
      ksum_q      <= 41'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_q       <= win_d;
      fill_q      <= fill_d;
      body_q      <= body_d;
      frames_q    <= frames_d;
      garbage_q   <= garbage_d;
      good_q      <= good_d;
      lrate_q     <= lrate_d;
      lkbps_q     <= lkbps_d;
      lver_q      <= lver_d;
      lstereo_q   <= lstereo_d;
      ksum_q      <= ksum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    eos_q   <= eos_d;
    cls_q   <= cls_d;
    fsize_q <= fsize_d;
    bad_q   <= bad_d;
    prod_q  <= prod_d;
    khz_q   <= khz_d;
    dur_q   <= dur_d;
    avg_q   <= avg_d;
    out_q   <= out_d;
  end

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

`ifndef NO_ASSERTIONS
  // A new byte is only taken when the divider has nothing in flight.
  a_idle_div_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !div_rsp.busy)
    else $error("divider busy while the scanner is idle");

  // Divider completions only arrive in states that wait for them.
  a_done_expected : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_SIZE || state_q == ST_DUR || state_q == ST_AVG))
    else $error("divider finished outside a waiting state");

  // Frame body can only be pending while the window is full.
  a_body_full_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (body_q != '0) |-> (fill_q == 2'd3))
    else $error("frame body pending with a partial window");

  // Delivering the final result starts a fresh stream.
  a_final_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && eos_q) |=> (frames_q == 32'd0 && fill_q == 2'd0 && out_o.payload.final_res))
    else $error("stream state not cleared after the final result");
`endif

endmodule
